### hdl/mwsl_pkg.sv
// Shared constants and types for the max window sum locator.
`default_nettype none

package mwsl_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 1024;
    localparam int MAX_K       = 16;
    localparam int SAMPLE_BITS = 16;

    // Fixed field widths of the ports
    localparam int K_CFG_BITS     = 5;
    localparam int DIM_BITS       = 11;
    localparam int CFG_DATA_BITS  = 11;
    localparam int CFG_INDEX_BITS = 2;
    localparam int SUM_OUT_BITS   = 24;
    localparam int POS_OUT_BITS   = 10;

    localparam int COL_BITS       = $clog2(MAX_WIDTH);
    localparam int ROW_BITS       = $clog2(MAX_HEIGHT);
    localparam int K_BITS         = $clog2(MAX_K) + 1;
    localparam int LINE_ROW_BITS  = $clog2(MAX_K);
    localparam int LINE_DEPTH     = MAX_K * MAX_WIDTH;
    localparam int LINE_ADDR_BITS = LINE_ROW_BITS + COL_BITS;
    localparam int COLSUM_BITS    = SAMPLE_BITS + $clog2(MAX_K) + 1;
    localparam int WIN_BITS       = COLSUM_BITS + $clog2(MAX_K);

    localparam logic [K_BITS-1:0]   K_RESET = K_BITS'(3);
    localparam logic [DIM_BITS-1:0] W_RESET = DIM_BITS'(MAX_WIDTH);
    localparam logic [DIM_BITS-1:0] H_RESET = DIM_BITS'(MAX_HEIGHT);

    localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_SIZE   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MATRIX_WIDTH  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MATRIX_HEIGHT = 2'd2;

    // Position tags of one item, set when the item is accepted
    typedef struct packed {
        logic [ROW_BITS-1:0] row;
        logic [COL_BITS-1:0] col;
        logic [ROW_BITS-1:0] top;
        logic [COL_BITS-1:0] left;
        logic                first_row;
        logic                drop_old;
        logic                first_col;
        logic                sub_left;
        logic                eval;
        logic                last;
    } t_pos;

    // Item leaving the column update stage
    typedef struct packed {
        logic signed [COLSUM_BITS-1:0] col_sum;
        t_pos                          pos;
    } t_col_item;

    // Item leaving the window sum stage
    typedef struct packed {
        logic signed [WIN_BITS-1:0] win_sum;
        t_pos                       pos;
    } t_win_item;

endpackage

`default_nettype wire

### hdl/max_window_sum_locator_unit.sv
// Top level of the max window sum locator: configuration, raster position and handshakes.
//
//   channel  direction  handshake                  payload
//   in       sink       i_in_valid / o_in_ready    i_sample
//   out      source     o_out_valid / i_out_ready  o_found, o_best_sum, o_best_row, o_best_col
//   cfg      sink       i_cfg_we                   i_cfg_index, i_cfg_data
//
// One sample is taken per cycle; the column sum memory is read on acceptance, updated and
// written back the next cycle, with forwarding from that write to the following read.
// After the last sample is accepted, the result moves through s1, s2 and s3 to the result register.
// A last sample is held off while another result is in flight or waiting on the out side;
// all other samples are taken every cycle regardless of output stalls.
// Reset is synchronous; the memories need no clearing pass (first row ignores old sums).
`default_nettype none

module max_window_sum_locator_unit (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_rst_n,
    input  wire logic                                        i_in_valid,
    output logic                                             o_in_ready,
    input  wire logic signed [mwsl_pkg::SAMPLE_BITS-1:0]     i_sample,
    output logic                                             o_out_valid,
    input  wire logic                                        i_out_ready,
    output logic                                             o_found,
    output logic signed [mwsl_pkg::SUM_OUT_BITS-1:0]         o_best_sum,
    output logic [mwsl_pkg::POS_OUT_BITS-1:0]                o_best_row,
    output logic [mwsl_pkg::POS_OUT_BITS-1:0]                o_best_col,
    input  wire logic                                        i_cfg_we,
    input  wire logic [mwsl_pkg::CFG_INDEX_BITS-1:0]         i_cfg_index,
    input  wire logic [mwsl_pkg::CFG_DATA_BITS-1:0]          i_cfg_data
);

    logic [mwsl_pkg::K_BITS-1:0]     r_k, n_k;
    logic [mwsl_pkg::DIM_BITS-1:0]   r_w, n_w;
    logic [mwsl_pkg::DIM_BITS-1:0]   r_h, n_h;
    logic [mwsl_pkg::ROW_BITS-1:0]   r_row, n_row;
    logic [mwsl_pkg::COL_BITS-1:0]   r_col, n_col;

    logic                            restart;
    logic                            accept;
    logic [mwsl_pkg::K_BITS-1:0]     k_m1;
    logic [mwsl_pkg::K_CFG_BITS-1:0] k_raw;
    logic [mwsl_pkg::DIM_BITS-1:0]   dim_raw;
    mwsl_pkg::t_pos                  pos;
    logic                            found;
    logic                            col_major;
    logic                            col_valid;
    mwsl_pkg::t_col_item             col_item;
    logic                            win_busy;

    assign k_raw   = mwsl_pkg::K_CFG_BITS'(i_cfg_data);
    assign dim_raw = mwsl_pkg::DIM_BITS'(i_cfg_data);

    // Saturate written values into their legal ranges; the window size comes from the low data bits
    always_comb begin
        n_k = r_k;
        n_w = r_w;
        n_h = r_h;
        restart = 1'b0;
        if (i_cfg_we) begin
            case (i_cfg_index)
                mwsl_pkg::CFG_WINDOW_SIZE: begin
                    restart = 1'b1;
                    if (k_raw == '0) begin
                        n_k = mwsl_pkg::K_BITS'(1);
                    end else if (32'(k_raw) > mwsl_pkg::MAX_K) begin
                        n_k = mwsl_pkg::K_BITS'(mwsl_pkg::MAX_K);
                    end else begin
                        n_k = mwsl_pkg::K_BITS'(k_raw);
                    end
                end
                mwsl_pkg::CFG_MATRIX_WIDTH: begin
                    restart = 1'b1;
                    if (dim_raw == '0) begin
                        n_w = mwsl_pkg::DIM_BITS'(1);
                    end else if (32'(dim_raw) > mwsl_pkg::MAX_WIDTH) begin
                        n_w = mwsl_pkg::DIM_BITS'(mwsl_pkg::MAX_WIDTH);
                    end else begin
                        n_w = dim_raw;
                    end
                end
                mwsl_pkg::CFG_MATRIX_HEIGHT: begin
                    restart = 1'b1;
                    if (dim_raw == '0) begin
                        n_h = mwsl_pkg::DIM_BITS'(1);
                    end else if (32'(dim_raw) > mwsl_pkg::MAX_HEIGHT) begin
                        n_h = mwsl_pkg::DIM_BITS'(mwsl_pkg::MAX_HEIGHT);
                    end else begin
                        n_h = dim_raw;
                    end
                end
                default: begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    assign k_m1 = r_k - mwsl_pkg::K_BITS'(1);

    always_comb begin
        pos.row       = r_row;
        pos.col       = r_col;
        pos.top       = r_row - mwsl_pkg::ROW_BITS'(k_m1);
        pos.left      = r_col - mwsl_pkg::COL_BITS'(k_m1);
        pos.first_row = (r_row == '0);
        pos.drop_old  = mwsl_pkg::DIM_BITS'(r_row) >= mwsl_pkg::DIM_BITS'(r_k);
        pos.first_col = (r_col == '0);
        pos.sub_left  = mwsl_pkg::DIM_BITS'(r_col) >= mwsl_pkg::DIM_BITS'(r_k);
        pos.eval      = (mwsl_pkg::DIM_BITS'(r_row) >= mwsl_pkg::DIM_BITS'(k_m1))
                     && (mwsl_pkg::DIM_BITS'(r_col) >= mwsl_pkg::DIM_BITS'(k_m1));
        pos.last      = (mwsl_pkg::DIM_BITS'(r_row) == r_h - mwsl_pkg::DIM_BITS'(1))
                     && (mwsl_pkg::DIM_BITS'(r_col) == r_w - mwsl_pkg::DIM_BITS'(1));
    end

    assign found     = (r_w >= mwsl_pkg::DIM_BITS'(r_k)) && (r_h >= mwsl_pkg::DIM_BITS'(r_k));
    assign col_major = r_h > r_w;

    // Hold a last sample until the result path is free; take nothing in reset
    assign o_in_ready = i_rst_n
                     && !(pos.last && (win_busy || (col_valid && col_item.pos.last)));
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (restart) begin
            n_row = '0;
            n_col = '0;
        end else if (accept) begin
            if (pos.last) begin
                n_row = '0;
                n_col = '0;
            end else if (mwsl_pkg::DIM_BITS'(r_col) == r_w - mwsl_pkg::DIM_BITS'(1)) begin
                n_col = '0;
                n_row = r_row + mwsl_pkg::ROW_BITS'(1);
            end else begin
                n_col = r_col + mwsl_pkg::COL_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k   <= mwsl_pkg::K_RESET;
            r_w   <= mwsl_pkg::W_RESET;
            r_h   <= mwsl_pkg::H_RESET;
            r_row <= '0;
            r_col <= '0;
        end else begin
            r_k   <= n_k;
            r_w   <= n_w;
            r_h   <= n_h;
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    mwsl_column_update u_column_update (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_pos    (pos),
        .i_sample (i_sample),
        .i_k      (r_k),
        .o_valid  (col_valid),
        .o_item   (col_item)
    );

    mwsl_window_best u_window_best (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_restart   (restart),
        .i_valid     (col_valid),
        .i_item      (col_item),
        .i_k         (r_k),
        .i_found     (found),
        .i_col_major (col_major),
        .i_out_ready (i_out_ready),
        .o_busy      (win_busy),
        .o_out_valid (o_out_valid),
        .o_found     (o_found),
        .o_best_sum  (o_best_sum),
        .o_best_row  (o_best_row),
        .o_best_col  (o_best_col)
    );

endmodule

`default_nettype wire

### hdl/mwsl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module mwsl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### hdl/mwsl_column_update.sv
// Line store and column sum memories with the read-modify-write of one column sum per item.
`default_nettype none

module mwsl_column_update (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_accept,
    input  wire mwsl_pkg::t_pos                      i_pos,
    input  wire logic signed [mwsl_pkg::SAMPLE_BITS-1:0] i_sample,
    input  wire logic [mwsl_pkg::K_BITS-1:0]         i_k,
    output logic                                     o_valid,
    output mwsl_pkg::t_col_item                      o_item
);

    logic                                        r_s1_valid;
    mwsl_pkg::t_pos                              r_s1_pos;
    logic signed [mwsl_pkg::SAMPLE_BITS-1:0]     r_s1_sample;

    logic                                        r_col_fwd_hit;
    logic signed [mwsl_pkg::COLSUM_BITS-1:0]     r_col_fwd_data;
    logic                                        r_line_fwd_hit;
    logic signed [mwsl_pkg::SAMPLE_BITS-1:0]     r_line_fwd_data;

    logic [mwsl_pkg::LINE_ADDR_BITS-1:0]         line_raddr;
    logic [mwsl_pkg::LINE_ADDR_BITS-1:0]         line_waddr;
    logic [mwsl_pkg::LINE_ROW_BITS-1:0]          old_row;
    logic [mwsl_pkg::SAMPLE_BITS-1:0]            line_q;
    logic [mwsl_pkg::COLSUM_BITS-1:0]            col_q;
    logic signed [mwsl_pkg::SAMPLE_BITS-1:0]     old_sample;
    logic signed [mwsl_pkg::COLSUM_BITS-1:0]     col_prev;
    logic signed [mwsl_pkg::COLSUM_BITS-1:0]     col_new;

    // Row k lines back sits in the circular line store
    assign old_row    = mwsl_pkg::LINE_ROW_BITS'(i_pos.row)
                      - mwsl_pkg::LINE_ROW_BITS'(i_k);
    assign line_raddr = {old_row, i_pos.col};
    assign line_waddr = {mwsl_pkg::LINE_ROW_BITS'(r_s1_pos.row), r_s1_pos.col};

    mwsl_ram #(
        .WIDTH (mwsl_pkg::SAMPLE_BITS),
        .DEPTH (mwsl_pkg::LINE_DEPTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (line_waddr),
        .i_wdata (r_s1_sample),
        .i_re    (i_accept),
        .i_raddr (line_raddr),
        .o_rdata (line_q)
    );

    mwsl_ram #(
        .WIDTH (mwsl_pkg::COLSUM_BITS),
        .DEPTH (mwsl_pkg::MAX_WIDTH)
    ) u_col_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_pos.col),
        .i_wdata (col_new),
        .i_re    (i_accept),
        .i_raddr (i_pos.col),
        .o_rdata (col_q)
    );

    // Take the value written in the same cycle as the read, if any
    always_comb begin
        old_sample = r_line_fwd_hit ? r_line_fwd_data : $signed(line_q);
        if (r_s1_pos.first_row) begin
            col_prev = '0;
        end else if (r_col_fwd_hit) begin
            col_prev = r_col_fwd_data;
        end else begin
            col_prev = $signed(col_q);
        end
        col_new = col_prev + mwsl_pkg::COLSUM_BITS'(r_s1_sample);
        if (r_s1_pos.drop_old) begin
            col_new = col_new - mwsl_pkg::COLSUM_BITS'(old_sample);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid     <= 1'b0;
            r_col_fwd_hit  <= 1'b0;
            r_line_fwd_hit <= 1'b0;
        end else begin
            r_s1_valid     <= i_accept;
            r_col_fwd_hit  <= i_accept && r_s1_valid && (i_pos.col == r_s1_pos.col);
            r_line_fwd_hit <= i_accept && r_s1_valid && (line_raddr == line_waddr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_pos    <= i_pos;
            r_s1_sample <= i_sample;
        end
        r_col_fwd_data  <= col_new;
        r_line_fwd_data <= r_s1_sample;
    end

    assign o_valid        = r_s1_valid;
    assign o_item.col_sum = col_new;
    assign o_item.pos     = r_s1_pos;

endmodule

`default_nettype wire

### hdl/mwsl_window_best.sv
// Horizontal window sum, best window tracking and the result register.
`default_nettype none

module mwsl_window_best (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_restart,
    input  wire logic                                 i_valid,
    input  wire mwsl_pkg::t_col_item                  i_item,
    input  wire logic [mwsl_pkg::K_BITS-1:0]          i_k,
    input  wire logic                                 i_found,
    input  wire logic                                 i_col_major,
    input  wire logic                                 i_out_ready,
    output logic                                      o_busy,
    output logic                                      o_out_valid,
    output logic                                      o_found,
    output logic signed [mwsl_pkg::SUM_OUT_BITS-1:0]  o_best_sum,
    output logic [mwsl_pkg::POS_OUT_BITS-1:0]         o_best_row,
    output logic [mwsl_pkg::POS_OUT_BITS-1:0]         o_best_col
);

    logic                                     r_s2_valid;
    mwsl_pkg::t_col_item                      r_s2;
    logic                                     r_s3_valid;
    mwsl_pkg::t_win_item                      r_s3;

    logic signed [mwsl_pkg::COLSUM_BITS-1:0]  r_taps [mwsl_pkg::MAX_K];
    logic signed [mwsl_pkg::WIN_BITS-1:0]     r_ws;
    logic signed [mwsl_pkg::WIN_BITS-1:0]     n_ws;
    logic signed [mwsl_pkg::COLSUM_BITS-1:0]  tap;

    logic signed [mwsl_pkg::WIN_BITS-1:0]     r_best_val;
    logic [mwsl_pkg::ROW_BITS-1:0]            r_best_top;
    logic [mwsl_pkg::COL_BITS-1:0]            r_best_left;
    logic signed [mwsl_pkg::WIN_BITS-1:0]     n_best_val;
    logic [mwsl_pkg::ROW_BITS-1:0]            n_best_top;
    logic [mwsl_pkg::COL_BITS-1:0]            n_best_left;
    logic                                     take;

    logic                                     r_out_valid;
    logic                                     r_out_found;
    logic signed [mwsl_pkg::SUM_OUT_BITS-1:0] r_out_sum;
    logic [mwsl_pkg::POS_OUT_BITS-1:0]        r_out_row;
    logic [mwsl_pkg::POS_OUT_BITS-1:0]        r_out_col;

    // Tap k-1 holds the column sum k columns to the left
    assign tap = r_taps[mwsl_pkg::LINE_ROW_BITS'(i_k - mwsl_pkg::K_BITS'(1))];

    always_comb begin
        n_ws = r_s2.pos.first_col ? '0 : r_ws;
        n_ws = n_ws + mwsl_pkg::WIN_BITS'(r_s2.col_sum);
        if (r_s2.pos.sub_left) begin
            n_ws = n_ws - mwsl_pkg::WIN_BITS'(tap);
        end
    end

    // Strictly greater wins; column-major ties above zero go to the leftmost, then topmost
    always_comb begin
        take = 1'b0;
        if (r_s3.pos.eval) begin
            if (r_s3.win_sum > r_best_val) begin
                take = 1'b1;
            end else if (i_col_major && (r_s3.win_sum == r_best_val)
                         && (r_best_val > 0)) begin
                take = (r_s3.pos.left < r_best_left)
                    || ((r_s3.pos.left == r_best_left) && (r_s3.pos.top < r_best_top));
            end
        end
        n_best_val  = take ? r_s3.win_sum  : r_best_val;
        n_best_top  = take ? r_s3.pos.top  : r_best_top;
        n_best_left = take ? r_s3.pos.left : r_best_left;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_best_val  <= '0;
            r_best_top  <= '0;
            r_best_left <= '0;
        end else begin
            r_s2_valid <= i_valid;
            r_s3_valid <= r_s2_valid;
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_restart) begin
                r_best_val  <= '0;
                r_best_top  <= '0;
                r_best_left <= '0;
            end else if (r_s3_valid) begin
                if (r_s3.pos.last) begin
                    // Emit and start the next matrix from a clean best
                    r_out_valid <= 1'b1;
                    r_best_val  <= '0;
                    r_best_top  <= '0;
                    r_best_left <= '0;
                end else begin
                    r_best_val  <= n_best_val;
                    r_best_top  <= n_best_top;
                    r_best_left <= n_best_left;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_s2 <= i_item;
        end
        if (r_s2_valid) begin
            r_ws         <= n_ws;
            r_s3.win_sum <= n_ws;
            r_s3.pos     <= r_s2.pos;
            r_taps[0]    <= r_s2.col_sum;
            for (int i = 1; i < mwsl_pkg::MAX_K; i++) begin
                r_taps[i] <= r_taps[i-1];
            end
        end
        if (r_s3_valid && r_s3.pos.last) begin
            r_out_found <= i_found;
            r_out_sum   <= i_found ? mwsl_pkg::SUM_OUT_BITS'(n_best_val) : '0;
            r_out_row   <= i_found ? mwsl_pkg::POS_OUT_BITS'(n_best_top) : '0;
            r_out_col   <= i_found ? mwsl_pkg::POS_OUT_BITS'(n_best_left) : '0;
        end
    end

    // A last item still in flight or a result not yet taken
    assign o_busy = (r_s2_valid && r_s2.pos.last) || (r_s3_valid && r_s3.pos.last)
                  || r_out_valid;

    assign o_out_valid = r_out_valid;
    assign o_found     = r_out_found;
    assign o_best_sum  = r_out_sum;
    assign o_best_row  = r_out_row;
    assign o_best_col  = r_out_col;

endmodule

`default_nettype wire

### hdl/mwsl_checker.sv
// Port-level checks on the max window sum locator, bound to the top level.
`default_nettype none

module mwsl_checker (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    o_out_valid,
    input  wire logic                                    i_out_ready,
    input  wire logic                                    o_found,
    input  wire logic signed [mwsl_pkg::SUM_OUT_BITS-1:0] o_best_sum,
    input  wire logic [mwsl_pkg::POS_OUT_BITS-1:0]       o_best_row,
    input  wire logic [mwsl_pkg::POS_OUT_BITS-1:0]       o_best_col
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_found)
            && $stable(o_best_sum) && $stable(o_best_row) && $stable(o_best_col))
        else $error("result changed while stalled");

    // Nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !o_out_valid)
        else $error("result valid after reset");

    // The best starts at zero and only grows
    a_sum_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_best_sum[mwsl_pkg::SUM_OUT_BITS-1])
        else $error("negative best sum");

    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> (o_best_sum == '0) && (o_best_row == '0)
            && (o_best_col == '0))
        else $error("fields set without a window");

    // A zero best never moved off the origin
    a_zero_at_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_best_sum == '0) |-> (o_best_row == '0) && (o_best_col == '0))
        else $error("zero best away from origin");

endmodule

bind max_window_sum_locator_unit mwsl_checker u_mwsl_checker (.*);

`default_nettype wire
